[rtl/rammt_pkg.sv]
// Shared types and constants for the running average / minimum / maximum tracker.
// Used by the controller, the datapath and the top level. No dependencies.
package rammt_pkg;

  // Sample and result width (signed Q16.16).
  localparam int VALUE_W    = 32;
  // Width of the magnitude of the difference between a sample and the result.
  localparam int DIFF_W     = VALUE_W + 1;
  // Counter width for the divider iterations (counts down from DIFF_W).
  localparam int ITER_W     = $clog2(DIFF_W + 1);
  // Configuration register widths.
  localparam int MODE_W     = 2;
  localparam int LIMIT_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TRACK_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COUNT_LIMIT = 2'd1;

  // Tracking modes.
  localparam logic [MODE_W-1:0] MODE_AVG = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MIN = 2'd1;
  localparam logic [MODE_W-1:0] MODE_MAX = 2'd2;

  // Request types.
  localparam logic REQ_ADD   = 1'b0;
  localparam logic REQ_CLEAR = 1'b1;

  // Start values of the minimum and maximum modes.
  localparam logic signed [VALUE_W-1:0] VALUE_MAX_POS = {1'b0, {(VALUE_W-1){1'b1}}};
  localparam logic signed [VALUE_W-1:0] VALUE_MAX_NEG = {1'b1, {(VALUE_W-1){1'b0}}};

  // Input request payload.
  typedef struct packed {
    logic                      req_type;
    logic signed [VALUE_W-1:0] sample;
  } in_req_t;

  // Result payload.
  typedef struct packed {
    logic signed [VALUE_W-1:0] tracked_value;
    logic                      is_valid;
  } out_rsp_t;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic ld_item;
    logic div_step;
    logic commit;
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic needs_div;
    logic div_last;
    logic out_busy;
  } dp_sts_t;

endpackage

[rtl/running_avg_min_max_tracker_top.sv]
// Running average / minimum / maximum tracker, top level.
// An average-mode add request is loaded, runs the radix-2 divider for one quotient bit per
// iteration and is committed; other requests are loaded and committed. A commit waits while
// the previous result is still stalled at the output. One request is in progress at a time:
// the input stalls until its result is committed. Synchronous active-low reset clears the mode,
// the limit, the result and the count to zero; no clearing pass is needed.
module running_avg_min_max_tracker_top import rammt_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_req_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_rsp_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  // Configuration writes are taken at any time.
  assign cfg_ready = 1'b1;

  // Controller.
  rammt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .sts      (sts),
    .cmd      (cmd),
    .in_stall (in_stall)
  );

  // Datapath.
  rammt_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // One request at a time: after an accepted request the input stalls.
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted while another is in progress");

  // A result is never committed over one that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !(out_valid && out_stall))
    else $error("result committed while output is stalled");

  // A new result shows only after a commit.
  a_out_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(cmd.commit))
    else $error("output valid without a commit");

  // Loading happens only on an accepted request.
  a_load_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ld_item |-> (in_valid && !in_stall))
    else $error("item loaded without an accepted request");
`endif

endmodule

[rtl/rammt_ctrl.sv]
// Controller state machine for the tracker: sequences load, divide and commit.
// Depends on rammt_pkg for the state, command and status types.
module rammt_ctrl import rammt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd,
  output logic     in_stall
);

  ctl_state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = sts.needs_div ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        if (sts.div_last) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!sts.out_busy) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.ld_item = in_valid;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_DONE: begin
        cmd.commit = !sts.out_busy;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

[rtl/rammt_dp.sv]
// Datapath for the tracker: configuration registers, state, a radix-2 restoring
// divider, the update logic and the result register. Depends on rammt_pkg.
module rammt_dp import rammt_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  in_req_t               in_data,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  out_stall,
  input  ctl_cmd_t              cmd,
  output dp_sts_t               sts,
  output logic                  out_valid,
  output out_rsp_t              out_data
);

  localparam int CMP_W = (COUNT_BITS > LIMIT_W) ? COUNT_BITS : LIMIT_W;
  localparam int REM_W = COUNT_BITS + 1;
  localparam int SUM_W = VALUE_W + 2;

  logic [MODE_W-1:0]         track_mode_r;
  logic [LIMIT_W-1:0]        count_limit_r;
  logic signed [VALUE_W-1:0] running_value_r, running_value_nxt;
  logic [COUNT_BITS-1:0]     sample_count_r, sample_count_nxt;

  logic                      req_clear_r;
  logic signed [VALUE_W-1:0] sample_r;
  logic                      d_neg_r;
  logic [DIFF_W-1:0]         quo_r;
  logic [REM_W-1:0]          rem_r;
  logic [ITER_W-1:0]         iter_r;

  logic                      out_valid_r;
  out_rsp_t                  out_data_r;

  logic signed [DIFF_W-1:0]  diff;
  logic [DIFF_W-1:0]         diff_mag;
  logic [REM_W-1:0]          divisor;
  logic [REM_W:0]            rem_shift;
  logic [REM_W:0]            rem_sub;
  logic                      rem_ge;
  logic signed [SUM_W-1:0]   quo_signed;
  logic signed [SUM_W-1:0]   avg_base;
  logic signed [SUM_W-1:0]   avg_fixed;
  logic                      count_inc;

  // Configuration writes; indexes beyond the list are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      track_mode_r  <= MODE_AVG;
      count_limit_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TRACK_MODE:  track_mode_r  <= cfg_data[MODE_W-1:0];
        REG_COUNT_LIMIT: count_limit_r <= cfg_data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // Difference between the new sample and the current result, as sign and magnitude.
  assign diff     = {in_data.sample[VALUE_W-1], in_data.sample}
                  - {running_value_r[VALUE_W-1], running_value_r};
  assign diff_mag = diff[DIFF_W-1] ? -diff : diff;

  // Divisor is the sample count plus one; the count is stable while an item runs.
  assign divisor   = REM_W'(sample_count_r) + REM_W'(1);
  assign rem_shift = {rem_r, quo_r[DIFF_W-1]};
  assign rem_sub   = rem_shift - {1'b0, divisor};
  assign rem_ge    = rem_shift >= {1'b0, divisor};

  // Item capture and divider iterations.
  always_ff @(posedge clk) begin
    if (cmd.ld_item) begin
      req_clear_r <= in_data.req_type;
      sample_r    <= in_data.sample;
      d_neg_r     <= diff[DIFF_W-1];
      quo_r       <= diff_mag;
      rem_r       <= '0;
      iter_r      <= ITER_W'(DIFF_W);
    end else if (cmd.div_step) begin
      rem_r  <= rem_ge ? rem_sub[REM_W-1:0] : rem_shift[REM_W-1:0];
      quo_r  <= {quo_r[DIFF_W-2:0], rem_ge};
      iter_r <= iter_r - ITER_W'(1);
    end
  end

  // Average: result plus the truncated quotient, moved one step toward zero
  // when the sum has the opposite sign to a nonzero remainder.
  always_comb begin
    quo_signed = d_neg_r ? -SUM_W'(quo_r) : SUM_W'(quo_r);
    avg_base   = SUM_W'(running_value_r) + quo_signed;
    avg_fixed  = avg_base;
    if ((rem_r != '0) && !d_neg_r && (avg_base < 0)) begin
      avg_fixed = avg_base + SUM_W'(1);
    end else if ((rem_r != '0) && d_neg_r && (avg_base > 0)) begin
      avg_fixed = avg_base - SUM_W'(1);
    end
  end

  // Count rises while below the limit and below its own maximum.
  assign count_inc = (CMP_W'(sample_count_r) < CMP_W'(count_limit_r))
                   && (sample_count_r != {COUNT_BITS{1'b1}});

  // New state for the item.
  always_comb begin
    running_value_nxt = running_value_r;
    sample_count_nxt  = sample_count_r;
    if (req_clear_r == REQ_CLEAR) begin
      sample_count_nxt = '0;
      case (track_mode_r)
        MODE_MIN: running_value_nxt = VALUE_MAX_POS;
        MODE_MAX: running_value_nxt = VALUE_MAX_NEG;
        default:  running_value_nxt = '0;
      endcase
    end else begin
      case (track_mode_r)
        MODE_AVG: running_value_nxt = avg_fixed[VALUE_W-1:0];
        MODE_MIN: begin
          if (sample_r < running_value_r) begin
            running_value_nxt = sample_r;
          end
        end
        MODE_MAX: begin
          if (sample_r > running_value_r) begin
            running_value_nxt = sample_r;
          end
        end
        default:  running_value_nxt = running_value_r;
      endcase
      if (count_inc) begin
        sample_count_nxt = sample_count_r + COUNT_BITS'(1);
      end
    end
  end

  // Tracked state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_value_r <= '0;
      sample_count_r  <= '0;
    end else if (cmd.commit) begin
      running_value_r <= running_value_nxt;
      sample_count_r  <= sample_count_nxt;
    end
  end

  // Result register; a new result loads when the previous one has been taken.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data_r.tracked_value <= running_value_nxt;
      out_data_r.is_valid      <= (sample_count_nxt != '0);
    end
  end

  // Status to the controller.
  assign sts.needs_div = (in_data.req_type == REQ_ADD) && (track_mode_r == MODE_AVG);
  assign sts.div_last  = (iter_r == ITER_W'(1));
  assign sts.out_busy  = out_valid_r && out_stall;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[dv/rammt_result_checker.sv]
// Result checker for the running average / minimum / maximum tracker.
// Depends on rammt_pkg; watches the request, result and register write channels of the top level.
`timescale 1ns / 1ps
module rammt_result_checker import rammt_pkg::*; #(
  parameter int COUNT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_stall,
  input  in_req_t               in_data,
  input  logic                  out_valid,
  input  logic                  out_stall,
  input  out_rsp_t              out_data,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           results_due,
  output int unsigned           mismatch_count
);

  // Shadow copy of the registers and of the tracker state.
  logic [MODE_W-1:0]         mode_q;
  logic [LIMIT_W-1:0]        limit_q;
  logic signed [VALUE_W-1:0] value_q;
  logic [COUNT_BITS-1:0]     count_q;

  // Results predicted for accepted requests, oldest first.
  out_rsp_t due_results[$];
  int unsigned errors;

  assign results_due    = due_results.size();
  assign mismatch_count = errors;

  // Exact truncated average of the old result weighted by n and the new sample.
  function automatic logic signed [VALUE_W-1:0] averaged(
    input logic signed [VALUE_W-1:0] cur,
    input logic signed [VALUE_W-1:0] smp,
    input logic [COUNT_BITS-1:0]     n
  );
    longint weighted;
    weighted = longint'(cur) * longint'(n) + longint'(smp);
    return VALUE_W'(weighted / (longint'(n) + 1));
  endfunction

  // Applies one request to the shadow state and returns the result it should produce.
  function automatic out_rsp_t track_request(input in_req_t req);
    out_rsp_t rsp;
    if (req.req_type == REQ_CLEAR) begin
      count_q = '0;
      case (mode_q)
        MODE_MIN: value_q = VALUE_MAX_POS;
        MODE_MAX: value_q = VALUE_MAX_NEG;
        default:  value_q = '0;
      endcase
    end else begin
      case (mode_q)
        MODE_AVG: value_q = averaged(value_q, req.sample, count_q);
        MODE_MIN: if (req.sample < value_q) value_q = req.sample;
        MODE_MAX: if (req.sample > value_q) value_q = req.sample;
        default: ;
      endcase
      // The count stops at the limit and at its own full scale.
      if (count_q < limit_q && count_q != '1) count_q = count_q + 1'b1;
    end
    rsp.tracked_value = value_q;
    rsp.is_valid      = (count_q != '0);
    return rsp;
  endfunction

  // Register writes, request predictions and result comparison, all at the rising edge.
  always @(posedge clk) begin : track_and_compare
    out_rsp_t want;
    if (!rst_n) begin
      mode_q  = MODE_AVG;
      limit_q = '0;
      value_q = '0;
      count_q = '0;
      due_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TRACK_MODE:  mode_q  = cfg_data[MODE_W-1:0];
          REG_COUNT_LIMIT: limit_q = cfg_data[LIMIT_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) due_results.push_back(track_request(in_data));
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("result with no request pending: tracked_value %0d, is_valid %0b",
                 out_data.tracked_value, out_data.is_valid);
          errors++;
        end else begin
          want = due_results.pop_front();
          if (out_data.tracked_value !== want.tracked_value) begin
            $error("tracked_value: expected %0d, actual %0d",
                   want.tracked_value, out_data.tracked_value);
            errors++;
          end
          if (out_data.is_valid !== want.is_valid) begin
            $error("is_valid: expected %0b, actual %0b", want.is_valid, out_data.is_valid);
            errors++;
          end
        end
      end
    end
  end

endmodule

[dv/tb_running_avg_min_max_tracker_top.sv]
// Testbench top for the running average / minimum / maximum tracker.
// Depends on rammt_pkg, running_avg_min_max_tracker_top and rammt_result_checker.
`timescale 1ns / 1ps
module tb_running_avg_min_max_tracker_top;
  import rammt_pkg::*;

  localparam int          COUNT_BITS      = 16;
  localparam int unsigned CYCLE_LIMIT     = 600000;
  localparam int          PHASES          = 9;
  localparam int          ITEMS_PER_PHASE = 66;
  localparam int          DRAIN_CYCLES    = 40;

  // Register indexes the block decodes to nothing, and the mode with no tracking.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [MODE_W-1:0]    MODE_NONE   = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_req_t               in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_rsp_t              out_data;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           results_due;
  int unsigned           mismatch_count;
  int unsigned           cycle_count;
  bit                    quiet_tail;

  running_avg_min_max_tracker_top #(.COUNT_BITS(COUNT_BITS)) dut (.*);

  rammt_result_checker #(.COUNT_BITS(COUNT_BITS)) checker_i (.*);

  // 100 MHz clock.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side back-pressure: stall bursts between free-running stretches.
  initial begin : out_stall_gen
    int run;
    forever begin
      if (!quiet_tail && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        run = $urandom_range(1, 19);
      end else begin
        out_stall <= 1'b0;
        run = $urandom_range(1, 40);
      end
      repeat (run) @(negedge clk);
    end
  end

  // Ends a hung run.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("running_avg_min_max_tracker_top: mismatch");
    $finish;
  end

  // Mix of extremes, small values, Q16.16 values near zero and raw random words.
  function automatic logic signed [VALUE_W-1:0] pick_sample();
    case ($urandom_range(0, 5))
      0:       return VALUE_MAX_POS - VALUE_W'($urandom_range(0, 3));
      1:       return VALUE_MAX_NEG + VALUE_W'($urandom_range(0, 3));
      2:       return VALUE_W'($urandom_range(0, 2000)) - 1000;
      3:       return VALUE_W'($urandom_range(0, 200 << 16)) - (100 << 16);
      default: return $urandom;
    endcase
  endfunction

  // Presents one request, with an optional idle gap first; returns at the falling edge
  // after it was accepted, leaving valid high.
  task automatic send_req(input logic req_type, input logic signed [VALUE_W-1:0] smp);
    int gap;
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_data.req_type <= req_type;
    in_data.sample   <= smp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  // Writes one register; drops valid after the write and returns with valid low.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Mode write with random upper bits, which the block must drop.
  task automatic write_mode(input logic [MODE_W-1:0] mode);
    write_reg(REG_TRACK_MODE, {(CFG_DATA_W - MODE_W)'($urandom), mode});
  endtask

  // Stops sending and waits until every result has come back.
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
  endtask

  // Stimulus and verdict.
  initial begin : stimulus
    logic [MODE_W-1:0]  mode;
    logic [LIMIT_W-1:0] limit;
    quiet_tail = 1'b0;
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset settings: average mode with a limit of zero, so the count never rises.
    send_req(REQ_ADD, 32'sd100);
    send_req(REQ_ADD, -32'sd7);
    finish_phase();

    // Average with a small cap: extremes, and truncation toward zero on both signs.
    write_reg(REG_COUNT_LIMIT, 16'd3);
    write_mode(MODE_AVG);
    send_req(REQ_CLEAR, VALUE_MAX_NEG);
    send_req(REQ_ADD, VALUE_MAX_POS);
    send_req(REQ_ADD, VALUE_MAX_NEG);
    send_req(REQ_ADD, -32'sd1);
    send_req(REQ_ADD, 32'sd1);
    send_req(REQ_ADD, -32'sd3);
    send_req(REQ_ADD, 32'sh0001_8000);
    finish_phase();

    // Minimum: first without a clear, so the average's state carries over.
    write_mode(MODE_MIN);
    send_req(REQ_ADD, 32'sd5);
    send_req(REQ_CLEAR, VALUE_MAX_POS);
    send_req(REQ_ADD, 32'sd5);
    send_req(REQ_ADD, VALUE_MAX_NEG);
    send_req(REQ_ADD, VALUE_MAX_POS);
    finish_phase();

    // Maximum from its start value.
    write_mode(MODE_MAX);
    send_req(REQ_CLEAR, '0);
    send_req(REQ_ADD, -32'sd5);
    send_req(REQ_ADD, VALUE_MAX_POS);
    send_req(REQ_ADD, VALUE_MAX_NEG);
    finish_phase();

    // Unused mode with all data bits set, writes to undecoded indexes, largest cap.
    write_reg(REG_TRACK_MODE, '1);
    write_reg(REG_SPARE_A, '1);
    write_reg(REG_SPARE_B, '1);
    write_reg(REG_COUNT_LIMIT, '1);
    send_req(REQ_ADD, 32'sd9);
    send_req(REQ_CLEAR, '1);
    send_req(REQ_ADD, 32'sd9);
    finish_phase();

    // Random phases, each with its own mode and cap; the last runs without idling.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0:       begin mode = MODE_AVG; limit = 16'd1; end
        1:       begin mode = MODE_AVG; limit = 16'd7; end
        2:       begin mode = MODE_AVG; limit = '1; end
        3:       begin mode = MODE_MIN; limit = LIMIT_W'($urandom); end
        4:       begin mode = MODE_MAX; limit = LIMIT_W'($urandom_range(0, 20)); end
        5:       begin mode = MODE_NONE; limit = LIMIT_W'($urandom_range(1, 5)); end
        6:       begin mode = MODE_AVG; limit = '0; end
        7:       begin mode = MODE_W'($urandom); limit = LIMIT_W'($urandom); end
        default: begin mode = MODE_AVG; limit = LIMIT_W'($urandom_range(2, 40)); end
      endcase
      if (p == PHASES - 1) quiet_tail = 1'b1;
      write_mode(mode);
      write_reg(REG_COUNT_LIMIT, limit);
      if ($urandom_range(0, 4) == 0)
        write_reg($urandom_range(0, 1) ? REG_SPARE_A : REG_SPARE_B, CFG_DATA_W'($urandom));
      if ($urandom_range(0, 3) != 0) send_req(REQ_CLEAR, pick_sample());
      for (int i = 0; i < ITEMS_PER_PHASE; i++)
        send_req(($urandom_range(0, 15) == 0) ? REQ_CLEAR : REQ_ADD, pick_sample());
      finish_phase();
    end

    // Let any stray result show up before the verdict.
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("running_avg_min_max_tracker_top: match");
    end else begin
      $display("running_avg_min_max_tracker_top: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/rammt_pkg.sv
rtl/rammt_ctrl.sv
rtl/rammt_dp.sv
rtl/running_avg_min_max_tracker_top.sv
dv/rammt_result_checker.sv
dv/tb_running_avg_min_max_tracker_top.sv
